// ----- rtl/afas_pkg.sv -----
// shared constants, types and the sign pattern table of the axis flip alignment selector
package afas_pkg;

  localparam int CoordBits   = 24;
  localparam int ElemBits    = 7;
  localparam int NumPatterns = 8;
  localparam int PatW        = $clog2(NumPatterns);
  localparam int SumW        = 63;
  localparam int QueueDepth  = 4;

  localparam logic [SumW-1:0] SumMax     = {SumW{1'b1}};
  localparam logic [63:0]     SqrtSumMax = 64'd3037000499;

  // bit 0 negates b x, bit 1 b y, bit 2 b z
  localparam logic [2:0] FlipTable [NumPatterns] = '{
    3'd0, 3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd7
  };

  typedef logic [SumW-1:0] sum_t;
  typedef sum_t [NumPatterns-1:0] sum_vec_t;

  // per pair contribution to each pattern sum, passed from front to back
  typedef struct packed {
    sum_vec_t sums;
    logic     mismatch;
    logic     last;
  } pair_t;

endpackage

// ----- rtl/axis_flip_alignment_selector.sv -----
// top level of the axis flip alignment selector
// Input channel (in_valid / in_stall): one pair per transfer, an A point and its
// B partner with element codes; last_pair closes a set. A pair is taken every cycle unless in_stall is high.
// For each of the eight sign patterns the block sums (a - s*b)^2 over x, y, z and
// all pairs of the set, saturating at 2^63-1; differing element codes set status.
// Output channel (out_valid / out_stall): one transfer per set, sent after its last
// pair: chosen pattern (lowest index on a tie), its flips, the least sum, status.
// A set's result, after its last pair is taken, passes three front stages
// (differences, squares, pattern contributions), the pair queue, the accumulate
// step and a two level min tree into the result register.
// Throughput: one pair per cycle when nothing stalls; the per pattern accumulate is a single
// add and saturate step, so consecutive pairs and sets follow each other without gaps.
// Reset (rst, synchronous) empties the pipeline and the queue and clears the sums
// and the mismatch flag. When the receiver stalls, the result holds; the front
// keeps taking pairs until the four entry queue and the min tree fill up.
module axis_flip_alignment_selector (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [afas_pkg::CoordBits-1:0] a_x,
  input  logic signed [afas_pkg::CoordBits-1:0] a_y,
  input  logic signed [afas_pkg::CoordBits-1:0] a_z,
  input  logic signed [afas_pkg::CoordBits-1:0] b_x,
  input  logic signed [afas_pkg::CoordBits-1:0] b_y,
  input  logic signed [afas_pkg::CoordBits-1:0] b_z,
  input  logic [afas_pkg::ElemBits-1:0]         a_element,
  input  logic [afas_pkg::ElemBits-1:0]         b_element,
  input  logic                                  last_pair,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [afas_pkg::PatW-1:0]             pattern,
  output logic                                  flip_x,
  output logic                                  flip_y,
  output logic                                  flip_z,
  output logic [afas_pkg::SumW-1:0]             min_sum,
  output logic                                  status
);
  import afas_pkg::*;

  logic  front_valid, front_stall;
  pair_t front_pair;
  logic  queue_valid, queue_stall;
  pair_t queue_pair;

  afas_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .a_x       (a_x),
    .a_y       (a_y),
    .a_z       (a_z),
    .b_x       (b_x),
    .b_y       (b_y),
    .b_z       (b_z),
    .a_element (a_element),
    .b_element (b_element),
    .last_pair (last_pair),
    .out_valid (front_valid),
    .out_stall (front_stall),
    .out_pair  (front_pair)
  );

  afas_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_stall  (front_stall),
    .in_pair   (front_pair),
    .out_valid (queue_valid),
    .out_stall (queue_stall),
    .out_pair  (queue_pair)
  );

  afas_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (queue_valid),
    .in_stall  (queue_stall),
    .in_pair   (queue_pair),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pattern   (pattern),
    .flip_x    (flip_x),
    .flip_y    (flip_y),
    .flip_z    (flip_z),
    .min_sum   (min_sum),
    .status    (status)
  );

endmodule

// ----- rtl/afas_front.sv -----
// front pipeline: differences, saturated squares and per pattern contributions of one pair
module afas_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [afas_pkg::CoordBits-1:0] a_x,
  input  logic signed [afas_pkg::CoordBits-1:0] a_y,
  input  logic signed [afas_pkg::CoordBits-1:0] a_z,
  input  logic signed [afas_pkg::CoordBits-1:0] b_x,
  input  logic signed [afas_pkg::CoordBits-1:0] b_y,
  input  logic signed [afas_pkg::CoordBits-1:0] b_z,
  input  logic [afas_pkg::ElemBits-1:0]       a_element,
  input  logic [afas_pkg::ElemBits-1:0]       b_element,
  input  logic                                last_pair,
  output logic                                out_valid,
  input  logic                                out_stall,
  output afas_pkg::pair_t                     out_pair
);
  import afas_pkg::*;

  localparam int DiffW  = CoordBits + 1;
  localparam int SqW    = 2 * DiffW;
  localparam int SqExtW = (SqW > 64) ? SqW : 64;

  logic signed [CoordBits-1:0] a_c [3];
  logic signed [CoordBits-1:0] b_c [3];
  logic [DiffW-1:0] mag_m_next [3];
  logic [DiffW-1:0] mag_p_next [3];
  logic [SumW-1:0]  sq_m_next [3];
  logic [SumW-1:0]  sq_p_next [3];
  sum_vec_t         tri_next;

  logic             s1_v, s2_v, s3_v;
  logic             s1_ready, s2_ready, s3_ready;
  logic [DiffW-1:0] s1_mag_m [3];
  logic [DiffW-1:0] s1_mag_p [3];
  logic             s1_mis, s1_last;
  logic [SumW-1:0]  s2_sq_m [3];
  logic [SumW-1:0]  s2_sq_p [3];
  logic             s2_mis, s2_last;

  function automatic logic [DiffW-1:0] abs_val(input logic signed [DiffW-1:0] d);
    logic signed [DiffW-1:0] n;
    n = -d;
    return d[DiffW-1] ? $unsigned(n) : $unsigned(d);
  endfunction

  function automatic logic [SumW-1:0] sat_square(input logic [DiffW-1:0] m);
    logic [SqW-1:0]    prod;
    logic [SqExtW-1:0] prod_ext;
    prod     = m * m;
    prod_ext = SqExtW'(prod);
    return (64'(m) > SqrtSumMax) ? SumMax : prod_ext[SumW-1:0];
  endfunction

  assign a_c[0] = a_x;
  assign a_c[1] = a_y;
  assign a_c[2] = a_z;
  assign b_c[0] = b_x;
  assign b_c[1] = b_y;
  assign b_c[2] = b_z;

  assign s3_ready = !s3_v || !out_stall;
  assign s2_ready = !s2_v || s3_ready;
  assign s1_ready = !s1_v || s2_ready;
  assign in_stall = !s1_ready;
  assign out_valid = s3_v;

  always_comb begin
    logic signed [DiffW-1:0] ae, be;
    for (int ax = 0; ax < 3; ax++) begin
      ae = $signed({a_c[ax][CoordBits-1], a_c[ax]});
      be = $signed({b_c[ax][CoordBits-1], b_c[ax]});
      mag_m_next[ax] = abs_val(ae - be);
      mag_p_next[ax] = abs_val(ae + be);
    end
  end

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      sq_m_next[ax] = sat_square(s1_mag_m[ax]);
      sq_p_next[ax] = sat_square(s1_mag_p[ax]);
    end
  end

  // a flipped axis uses the square of a + b
  always_comb begin
    logic [SumW+1:0] tot;
    for (int k = 0; k < NumPatterns; k++) begin
      tot = '0;
      for (int ax = 0; ax < 3; ax++) begin
        tot = tot + (FlipTable[k][ax] ? (SumW+2)'(s2_sq_p[ax]) : (SumW+2)'(s2_sq_m[ax]));
      end
      tri_next[k] = (tot > (SumW+2)'(SumMax)) ? SumMax : tot[SumW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      if (s1_ready) s1_v <= in_valid;
      if (s2_ready) s2_v <= s1_v;
      if (s3_ready) s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_mag_m <= mag_m_next;
      s1_mag_p <= mag_p_next;
      s1_mis   <= (a_element != b_element);
      s1_last  <= last_pair;
    end
    if (s2_ready && s1_v) begin
      s2_sq_m <= sq_m_next;
      s2_sq_p <= sq_p_next;
      s2_mis  <= s1_mis;
      s2_last <= s1_last;
    end
    if (s3_ready && s2_v) begin
      out_pair.sums     <= tri_next;
      out_pair.mismatch <= s2_mis;
      out_pair.last     <= s2_last;
    end
  end

endmodule

// ----- rtl/afas_queue.sv -----
// short queue of pair contributions between front and back
module afas_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  afas_pkg::pair_t in_pair,
  output logic            out_valid,
  input  logic            out_stall,
  output afas_pkg::pair_t out_pair
);
  import afas_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  pair_t           mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            push, pop;

  assign in_stall  = (count == CntW'(QueueDepth));
  assign out_valid = (count != '0);
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign out_pair  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_pair;
  end

endmodule

// ----- rtl/afas_back.sv -----
// back end: pattern sum accumulation, least sum search and result register
module afas_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  afas_pkg::pair_t            in_pair,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [afas_pkg::PatW-1:0]  pattern,
  output logic                       flip_x,
  output logic                       flip_y,
  output logic                       flip_z,
  output logic [afas_pkg::SumW-1:0]  min_sum,
  output logic                       status
);
  import afas_pkg::*;

  sum_vec_t        sums, sums_next;
  logic            mismatch_seen;
  logic            take;

  logic            fin_v, l1_v, l2_v, o_v;
  logic            fin_ready, l1_ready, l2_ready, o_ready;
  sum_vec_t        fin_sums;
  logic            fin_mis;
  sum_t            l1_val [4];
  logic [PatW-1:0] l1_idx [4];
  logic            l1_mis;
  sum_t            l2_val [2];
  logic [PatW-1:0] l2_idx [2];
  logic            l2_mis;
  logic [PatW-1:0] best_idx;

  assign o_ready   = !o_v || !out_stall;
  assign l2_ready  = !l2_v || o_ready;
  assign l1_ready  = !l1_v || l2_ready;
  assign fin_ready = !fin_v || l1_ready;
  // a last pair waits until the finish register is free
  assign in_stall  = in_pair.last && !fin_ready;
  assign take      = in_valid && !in_stall;
  assign out_valid = o_v;

  always_comb begin
    logic [SumW:0] tot;
    for (int k = 0; k < NumPatterns; k++) begin
      tot = (SumW+1)'(sums[k]) + (SumW+1)'(in_pair.sums[k]);
      sums_next[k] = tot[SumW] ? SumMax : tot[SumW-1:0];
    end
  end

  assign best_idx = (l2_val[1] < l2_val[0]) ? l2_idx[1] : l2_idx[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sums          <= '0;
      mismatch_seen <= 1'b0;
      fin_v         <= 1'b0;
      l1_v          <= 1'b0;
      l2_v          <= 1'b0;
      o_v           <= 1'b0;
    end else begin
      if (take) begin
        if (in_pair.last) begin
          sums          <= '0;
          mismatch_seen <= 1'b0;
        end else begin
          sums          <= sums_next;
          mismatch_seen <= mismatch_seen || in_pair.mismatch;
        end
      end
      if (fin_ready) fin_v <= take && in_pair.last;
      if (l1_ready)  l1_v  <= fin_v;
      if (l2_ready)  l2_v  <= l1_v;
      if (o_ready)   o_v   <= l2_v;
    end
  end

  // lower index sits on the left at every level and wins a tie
  always_ff @(posedge clk) begin
    if (fin_ready && take && in_pair.last) begin
      fin_sums <= sums_next;
      fin_mis  <= mismatch_seen || in_pair.mismatch;
    end
    if (l1_ready && fin_v) begin
      for (int i = 0; i < 4; i++) begin
        if (fin_sums[2*i+1] < fin_sums[2*i]) begin
          l1_val[i] <= fin_sums[2*i+1];
          l1_idx[i] <= PatW'(2*i+1);
        end else begin
          l1_val[i] <= fin_sums[2*i];
          l1_idx[i] <= PatW'(2*i);
        end
      end
      l1_mis <= fin_mis;
    end
    if (l2_ready && l1_v) begin
      for (int i = 0; i < 2; i++) begin
        if (l1_val[2*i+1] < l1_val[2*i]) begin
          l2_val[i] <= l1_val[2*i+1];
          l2_idx[i] <= l1_idx[2*i+1];
        end else begin
          l2_val[i] <= l1_val[2*i];
          l2_idx[i] <= l1_idx[2*i];
        end
      end
      l2_mis <= l1_mis;
    end
    if (o_ready && l2_v) begin
      pattern <= best_idx;
      flip_x  <= FlipTable[best_idx][0];
      flip_y  <= FlipTable[best_idx][1];
      flip_z  <= FlipTable[best_idx][2];
      min_sum <= (l2_val[1] < l2_val[0]) ? l2_val[1] : l2_val[0];
      status  <= l2_mis;
    end
  end

endmodule
